FILE: rtl/playfair_digraph_cipher_macros.svh
// Assertion macros for the Playfair digraph cipher.
// Needs clk and rst_n in the scope of the including module.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define PFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define PFC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pfc_pkg.sv
// Shared types and constants for the Playfair digraph cipher.
// No dependencies.
package pfc_pkg;

    localparam int CODE_W       = 5;
    localparam int SIDE         = 5;
    localparam int CELLS        = 25;
    localparam int LETTER_COUNT = 26;
    localparam int IDX_W        = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 50;
    localparam int FIRST_CELLS  = 10;
    localparam int MIDDLE_CELLS = 10;
    localparam int LAST_CELLS   = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_MIDDLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LAST   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT    = 2'd3;

    typedef struct packed {
        logic [CODE_W-1:0] first_letter;
        logic [CODE_W-1:0] second_letter;
        logic              last_pair;
    } in_item_t;

    typedef struct packed {
        logic [CODE_W-1:0] out_first;
        logic [CODE_W-1:0] out_second;
        logic              not_in_square;
        logic              last_out;
    } out_item_t;

endpackage

FILE: rtl/playfair_digraph_cipher.sv
// Playfair digraph cipher top level: key square registers, input and result stages.
// Depends on pfc_pkg and playfair_digraph_cipher_macros.svh.
//
// One digraph is taken in every clock cycle (busy stays low); each transfer
// gives one result via the input register and then the result register, with
// the square lookup and corner selection between them, shown for exactly one
// cycle with done high. The receiver cannot stall the block, so results must
// be captured when done is high. The user must write key cells and mode through
// the cfg port only while no digraph is in flight; the block does not enforce it.
`include "playfair_digraph_cipher_macros.svh"

module playfair_digraph_cipher (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  pfc_pkg::in_item_t                     item,
    output logic                                  done,
    output pfc_pkg::out_item_t                    result,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pfc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pfc_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import pfc_pkg::*;

    logic [CODE_W*FIRST_CELLS-1:0]  key_first_reg;
    logic [CODE_W*MIDDLE_CELLS-1:0] key_middle_reg;
    logic [CODE_W*LAST_CELLS-1:0]   key_last_reg;
    logic                           decrypt_reg;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;

    logic [CODE_W-1:0] cells [CELLS];

    logic            found_a, found_b;
    logic [IDX_W-1:0] row_a, col_a, row_b, col_b;
    logic [IDX_W-1:0] new_row_a, new_col_a, new_row_b, new_col_b;

    function automatic logic [IDX_W-1:0] wrap_step(input logic [IDX_W-1:0] x,
                                                  input logic back);
        logic [IDX_W-1:0] y;
        if (back)
        begin
            y = (x == '0) ? IDX_W'(SIDE - 1) : x - IDX_W'(1);
        end
        else
        begin
            y = (x == IDX_W'(SIDE - 1)) ? '0 : x + IDX_W'(1);
        end
        return y;
    endfunction

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign done      = out_valid_reg;
    assign result    = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_first_reg  <= '0;
            key_middle_reg <= '0;
            key_last_reg   <= '0;
            decrypt_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_KEY_FIRST:  key_first_reg  <= cfg_data[CODE_W*FIRST_CELLS-1:0];
                CFG_KEY_MIDDLE: key_middle_reg <= cfg_data[CODE_W*MIDDLE_CELLS-1:0];
                CFG_KEY_LAST:   key_last_reg   <= cfg_data[CODE_W*LAST_CELLS-1:0];
                CFG_DECRYPT:    decrypt_reg    <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < FIRST_CELLS; i++)
        begin
            cells[5'(i)] = key_first_reg[CODE_W*i +: CODE_W];
        end
        for (int i = 0; i < MIDDLE_CELLS; i++)
        begin
            cells[5'(FIRST_CELLS + i)] = key_middle_reg[CODE_W*i +: CODE_W];
        end
        for (int i = 0; i < LAST_CELLS; i++)
        begin
            cells[5'(FIRST_CELLS + MIDDLE_CELLS + i)] = key_last_reg[CODE_W*i +: CODE_W];
        end
    end

    // Locate both letters; the highest matching cell wins.
    always_comb
    begin
        found_a = 1'b0;
        found_b = 1'b0;
        row_a   = '0;
        col_a   = '0;
        row_b   = '0;
        col_b   = '0;
        for (int r = 0; r < SIDE; r++)
        begin
            for (int c = 0; c < SIDE; c++)
            begin
                if (in_item_reg.first_letter < CODE_W'(LETTER_COUNT) &&
                    cells[5'(r*SIDE + c)] == in_item_reg.first_letter)
                begin
                    found_a = 1'b1;
                    row_a   = IDX_W'(r);
                    col_a   = IDX_W'(c);
                end
                if (in_item_reg.second_letter < CODE_W'(LETTER_COUNT) &&
                    cells[5'(r*SIDE + c)] == in_item_reg.second_letter)
                begin
                    found_b = 1'b1;
                    row_b   = IDX_W'(r);
                    col_b   = IDX_W'(c);
                end
            end
        end
    end

    always_comb
    begin
        new_row_a = row_a;
        new_col_a = col_a;
        new_row_b = row_b;
        new_col_b = col_b;
        if (col_a == col_b)
        begin
            new_row_a = wrap_step(row_a, decrypt_reg);
            new_row_b = wrap_step(row_b, decrypt_reg);
        end
        else if (row_a == row_b)
        begin
            new_col_a = wrap_step(col_a, decrypt_reg);
            new_col_b = wrap_step(col_b, decrypt_reg);
        end
        else
        begin
            new_col_a = col_b;
            new_col_b = col_a;
        end

        out_item_next.last_out = in_item_reg.last_pair;
        if (found_a && found_b)
        begin
            out_item_next.not_in_square = 1'b0;
            out_item_next.out_first  = cells[5'(new_row_a * SIDE + new_col_a)];
            out_item_next.out_second = cells[5'(new_row_b * SIDE + new_col_b)];
        end
        else
        begin
            out_item_next.not_in_square = 1'b1;
            out_item_next.out_first     = '0;
            out_item_next.out_second    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= start && !busy;
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_item_reg <= item;
        end
        if (in_valid_reg)
        begin
            out_item_reg <= out_item_next;
        end
    end

    `PFC_ASSERT_NEXT(a_accept_to_stage, start && !busy, in_valid_reg, "transfer not staged")
    `PFC_ASSERT_NEXT(a_stage_to_done, in_valid_reg, done, "staged item gave no result")
    `PFC_ASSERT_SAME(a_missing_zero, done && result.not_in_square,
                     result.out_first == '0 && result.out_second == '0,
                     "missing letter with nonzero output")
    `PFC_ASSERT_NEXT(a_last_copied, in_valid_reg,
                     result.last_out == $past(in_item_reg.last_pair),
                     "last marker not carried")

endmodule
